[hw/rtl/dec_pkg.sv]
// shared constants, types and helpers for the difference equation controller
package dec_pkg;

  // data and coefficient formats
  localparam int DATA_W      = 16;
  localparam int COEF_W      = 16;
  localparam int FRAC_BITS   = 14;
  localparam int PROD_W      = DATA_W + COEF_W;
  localparam int ACC_W       = PROD_W + 4;
  localparam int Q_W         = ACC_W - FRAC_BITS;

  // history windows: command cells first, then measurement cells
  localparam int HIST_DEPTH  = 4;
  localparam int RING_LEN    = 2 * HIST_DEPTH;
  localparam int STEP_W      = $clog2(RING_LEN);
  localparam int HIST_IDX_W  = $clog2(HIST_DEPTH);
  localparam int CFG_IDX_W   = 8;

  // tap counts, clipped to the window depth
  localparam int FWD_TAPS    = 4;
  localparam int FB_TAPS     = 4;
  localparam int FWD_USED    = (FWD_TAPS < 1) ? 1 :
                               ((FWD_TAPS > HIST_DEPTH) ? HIST_DEPTH : FWD_TAPS);
  localparam int FB_USED     = (FB_TAPS < 1) ? 1 :
                               ((FB_TAPS > HIST_DEPTH) ? HIST_DEPTH : FB_TAPS);

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_ACC,
    ST_OUT
  } state_t;

  // per-cell control
  typedef struct packed {
    logic shift;
    logic rotate;
    logic coef_we;
  } cell_ctl_t;

  // multiply-accumulate control
  typedef struct packed {
    logic clear;
    logic en;
    logic sub;
  } mac_ctl_t;

  // true when the ring position at the head during this step carries a live tap
  function automatic logic term_used(input logic [STEP_W-1:0] step);
    logic                  is_fb;
    logic [HIST_IDX_W-1:0] tap;
    logic                  used;
    is_fb = step[STEP_W-1];
    tap   = step[HIST_IDX_W-1:0];
    if (is_fb) begin
      used = ({1'b0, tap} < (HIST_IDX_W + 1)'(FB_USED));
    end else begin
      used = ({1'b0, tap} < (HIST_IDX_W + 1)'(FWD_USED));
    end
    return used;
  endfunction

endpackage

[hw/rtl/dec_cell.sv]
// one history cell: a sample and its coefficient, shifted or rotated along the ring
module dec_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dec_pkg::cell_ctl_t                ctl,
  input  logic signed [dec_pkg::DATA_W-1:0] shift_val,
  input  logic signed [dec_pkg::DATA_W-1:0] rot_val,
  input  logic signed [dec_pkg::COEF_W-1:0] rot_coef,
  input  logic        [dec_pkg::COEF_W-1:0] cfg_data,
  output logic signed [dec_pkg::DATA_W-1:0] val,
  output logic signed [dec_pkg::COEF_W-1:0] coef
);

  logic signed [dec_pkg::DATA_W-1:0] val_r, val_nxt;
  logic signed [dec_pkg::COEF_W-1:0] coef_r, coef_nxt;

  // sample: push from the younger neighbor, or rotate toward the head
  always_comb begin
    priority if (ctl.shift) begin
      val_nxt = shift_val;
    end else if (ctl.rotate) begin
      val_nxt = rot_val;
    end else begin
      val_nxt = val_r;
    end
  end

  // coefficient: register write, or rotate together with the sample
  always_comb begin
    priority if (ctl.coef_we) begin
      coef_nxt = signed'(cfg_data);
    end else if (ctl.rotate) begin
      coef_nxt = rot_coef;
    end else begin
      coef_nxt = coef_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r  <= '0;
      coef_r <= '0;
    end else begin
      val_r  <= val_nxt;
      coef_r <= coef_nxt;
    end
  end

  assign val  = val_r;
  assign coef = coef_r;

endmodule

[hw/rtl/dec_mac.sv]
// shared multiply-accumulate unit with the final shift and saturation
module dec_mac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dec_pkg::mac_ctl_t                 ctl,
  input  logic signed [dec_pkg::DATA_W-1:0] sample,
  input  logic signed [dec_pkg::COEF_W-1:0] coef,
  output logic signed [dec_pkg::DATA_W-1:0] drive_value,
  output logic                              saturated
);

  logic signed [dec_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic                              prod_en_r, prod_en_nxt;
  logic                              prod_sub_r, prod_sub_nxt;
  logic signed [dec_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [dec_pkg::ACC_W-1:0]  prod_ext;
  logic signed [dec_pkg::Q_W-1:0]    q;
  logic                              hi_ok;

  // product stage
  always_comb begin
    prod_nxt     = dec_pkg::PROD_W'(sample) * dec_pkg::PROD_W'(coef);
    prod_en_nxt  = ctl.en;
    prod_sub_nxt = ctl.sub;
  end

  // accumulate stage
  always_comb begin
    prod_ext = {{(dec_pkg::ACC_W - dec_pkg::PROD_W){prod_r[dec_pkg::PROD_W-1]}}, prod_r};
    priority if (ctl.clear) begin
      acc_nxt = '0;
    end else if (prod_en_r && prod_sub_r) begin
      acc_nxt = acc_r - prod_ext;
    end else if (prod_en_r) begin
      acc_nxt = acc_r + prod_ext;
    end else begin
      acc_nxt = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    prod_sub_r <= prod_sub_nxt;
    if (!rst_n) begin
      prod_en_r <= 1'b0;
      acc_r     <= '0;
    end else begin
      prod_en_r <= prod_en_nxt;
      acc_r     <= acc_nxt;
    end
  end

  // floor shift, then clip to 16 bits
  always_comb begin
    q     = acc_r[dec_pkg::ACC_W-1:dec_pkg::FRAC_BITS];
    hi_ok = (q[dec_pkg::Q_W-1:dec_pkg::DATA_W-1] == '0) ||
            (q[dec_pkg::Q_W-1:dec_pkg::DATA_W-1] == '1);
    saturated = !hi_ok;
    if (hi_ok) begin
      drive_value = q[dec_pkg::DATA_W-1:0];
    end else if (q[dec_pkg::Q_W-1]) begin
      drive_value = {1'b1, {(dec_pkg::DATA_W-1){1'b0}}};
    end else begin
      drive_value = {1'b0, {(dec_pkg::DATA_W-1){1'b1}}};
    end
  end

endmodule

[hw/rtl/difference_equation_controller.sv]
// top level: ring of history cells, sequencer and output register
// Each accepted word first pushes the new command and/or measurement into
// their four-deep history windows (newest first), then the ring of eight
// cells rotates once around, bringing one sample and its Q2.14 coefficient
// per cycle to a single multiply-accumulate unit; measurement terms are
// subtracted. The sum is floor-shifted by 14 and clipped to signed 16 bits,
// with out_saturated flagging a clip. From acceptance to the next
// acceptance a word passes the accept step, eight MAC steps (one per ring
// cell), a step to drain the product register and one to load the output
// register, which waits while an unread result is held. A finished result
// waits there while the next word is taken in. Coefficients are written at
// cfg_index 0..7 (forward taps 0..3, then feedback taps 0..3); the user must
// do so only while idle (not enforced by the block); other indexes are ignored.
module difference_equation_controller (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_push_cmd,
  input  logic signed [dec_pkg::DATA_W-1:0]    in_new_cmd,
  input  logic                                 in_push_meas,
  input  logic signed [dec_pkg::DATA_W-1:0]    in_new_meas,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [dec_pkg::DATA_W-1:0]    out_drive_value,
  output logic                                 out_saturated,
  // configuration
  input  logic                                 cfg_we,
  input  logic        [dec_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [dec_pkg::COEF_W-1:0]    cfg_data
);

  dec_pkg::state_t                   state_r, state_nxt;
  logic [dec_pkg::STEP_W-1:0]        step_r, step_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic signed [dec_pkg::DATA_W-1:0] drive_r, drive_nxt;
  logic                              sat_r, sat_nxt;

  logic                              accept;
  logic                              out_load;
  logic                              shift_cmd;
  logic                              shift_meas;
  logic                              rotate;
  dec_pkg::mac_ctl_t                 mac_ctl;
  dec_pkg::cell_ctl_t                cell_ctl [dec_pkg::RING_LEN];
  logic signed [dec_pkg::DATA_W-1:0] cell_val  [dec_pkg::RING_LEN];
  logic signed [dec_pkg::COEF_W-1:0] cell_coef [dec_pkg::RING_LEN];
  logic signed [dec_pkg::DATA_W-1:0] mac_drive;
  logic                              mac_sat;

  assign accept = in_valid && in_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      dec_pkg::ST_IDLE: begin
        step_nxt = '0;
        if (accept) begin
          state_nxt = dec_pkg::ST_MAC;
        end
      end
      dec_pkg::ST_MAC: begin
        step_nxt = step_r + 1'b1;
        if (step_r == dec_pkg::STEP_W'(dec_pkg::RING_LEN - 1)) begin
          state_nxt = dec_pkg::ST_ACC;
        end
      end
      dec_pkg::ST_ACC: begin
        state_nxt = dec_pkg::ST_OUT;
      end
      dec_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = dec_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dec_pkg::ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready    = 1'b0;
    shift_cmd   = 1'b0;
    shift_meas  = 1'b0;
    rotate      = 1'b0;
    out_load    = 1'b0;
    mac_ctl     = '0;
    unique case (state_r)
      dec_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        shift_cmd     = in_valid && in_push_cmd;
        shift_meas    = in_valid && in_push_meas;
        mac_ctl.clear = in_valid;
      end
      dec_pkg::ST_MAC: begin
        rotate      = 1'b1;
        mac_ctl.en  = dec_pkg::term_used(step_r);
        mac_ctl.sub = step_r[dec_pkg::STEP_W-1];
      end
      dec_pkg::ST_ACC: begin
      end
      dec_pkg::ST_OUT: begin
        out_load = !out_valid_r || out_ready;
      end
      default: begin
      end
    endcase
  end

  // per-cell control: push per window, rotate all, coefficient write by index
  always_comb begin
    for (int i = 0; i < dec_pkg::RING_LEN; i++) begin
      cell_ctl[i].shift   = (i < dec_pkg::HIST_DEPTH) ? shift_cmd : shift_meas;
      cell_ctl[i].rotate  = rotate;
      cell_ctl[i].coef_we = cfg_we && (cfg_index == dec_pkg::CFG_IDX_W'(i));
    end
  end

  // ring of cells: pushes move away from the window head, rotation moves toward cell 0
  for (genvar g = 0; g < dec_pkg::RING_LEN; g++) begin : g_cell
    logic signed [dec_pkg::DATA_W-1:0] shift_src;
    if (g == 0) begin : g_cmd_head
      assign shift_src = in_new_cmd;
    end else if (g == dec_pkg::HIST_DEPTH) begin : g_meas_head
      assign shift_src = in_new_meas;
    end else begin : g_body
      assign shift_src = cell_val[g-1];
    end

    dec_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (cell_ctl[g]),
      .shift_val (shift_src),
      .rot_val   (cell_val[(g + 1) % dec_pkg::RING_LEN]),
      .rot_coef  (cell_coef[(g + 1) % dec_pkg::RING_LEN]),
      .cfg_data  (cfg_data),
      .val       (cell_val[g]),
      .coef      (cell_coef[g])
    );
  end

  dec_mac u_mac (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (mac_ctl),
    .sample      (cell_val[0]),
    .coef        (cell_coef[0]),
    .drive_value (mac_drive),
    .saturated   (mac_sat)
  );

  // output register
  always_comb begin
    drive_nxt     = out_load ? mac_drive : drive_r;
    sat_nxt       = out_load ? mac_sat : sat_r;
    out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    drive_r <= drive_nxt;
    sat_r   <= sat_nxt;
    if (!rst_n) begin
      state_r     <= dec_pkg::ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drive_value = drive_r;
  assign out_saturated   = sat_r;

  // an accepted word starts the ring sweep at step zero
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == dec_pkg::ST_MAC) && (step_r == '0))
    else $error("accepted word did not start the MAC sweep");

  // the sweep lasts exactly one full turn of the ring
  a_sweep_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dec_pkg::ST_MAC) && (step_r == dec_pkg::STEP_W'(dec_pkg::RING_LEN - 1))
    |=> (state_r == dec_pkg::ST_ACC))
    else $error("MAC sweep did not end after one ring turn");

  // no word is accepted while a sweep is in progress
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dec_pkg::ST_MAC) || (state_r == dec_pkg::ST_ACC) |-> !accept)
    else $error("word accepted during a sweep");

  // a clipped result sits at one of the range limits
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && sat_r |->
      (drive_r == 16'sh7fff) || (drive_r == -16'sh8000))
    else $error("saturated flag without a limit value");

endmodule
